// ----- rtl/core/ktf_pkg.sv -----
// ktf_pkg: shared widths, register map, reset values, types and fixed-point
// helpers for the two-axis tilt filter. No dependencies.
`timescale 1ns / 1ps

package ktf_pkg;

  // field and register widths
  localparam int TS_W    = 24;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  // register map (index = paddr[3:2])
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [1:0] REG_PROCESS_NOISE = 2'd1;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

  // reset values
  localparam logic [TS_W-1:0]   SAMPLE_PERIOD_RST = 24'd167772;
  localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd1048576;
  localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd589824;
  localparam logic [DATA_W-1:0] VAR_RST           = 32'd262144;

  // shared multiplier and divider widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RND_W   = PROD_W - 24;
  localparam int SUM_W   = 37;
  localparam int NUM_W   = 57;
  localparam int DEN_W   = 33;
  localparam int K_W     = 25;
  localparam int CNT_W   = 5;

  localparam logic [K_W-1:0]   ONE_Q24   = 25'h1000000;
  localparam logic [CNT_W-1:0] DIV_LAST  = 5'd24;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [RND_W-1:0]   rnd_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    logic [TS_W-1:0]   sample_period;
    logic [DATA_W-1:0] process_noise_sq;
    logic [DATA_W-1:0] measure_noise_sq;
  } ktf_cfg_t;

  // rescale by 2^-24, round half up (floor of v + 2^23)
  function automatic rnd_t round_q24(input prod_t v);
    prod_t b;
    b = v + prod_t'(64'sd8388608);
    return b[PROD_W-1:24];
  endfunction

  // clamp to signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat_s32(input sum_t v);
    logic signed [DATA_W-1:0] res;
    if (v[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){v[SUM_W-1]}}) begin
      res = v[SUM_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

  // clamp to unsigned 32-bit range
  function automatic logic [DATA_W-1:0] sat_u32(input sum_t v);
    logic [DATA_W-1:0] res;
    if (v[SUM_W-1]) begin
      res = '0;
    end else if (|v[SUM_W-2:DATA_W]) begin
      res = '1;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/ktf_regs.sv -----
// ktf_regs: APB-style configuration registers of the tilt filter.
// Depends on ktf_pkg for the register map and reset values.
`timescale 1ns / 1ps

module ktf_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ktf_pkg::PADDR_W-1:0] paddr,
  input  logic [ktf_pkg::DATA_W-1:0]  pwdata,
  output logic [ktf_pkg::DATA_W-1:0]  prdata,
  output ktf_pkg::ktf_cfg_t          cfg
);
  import ktf_pkg::*;

  logic [TS_W-1:0]   sample_period_r;
  logic [DATA_W-1:0] process_noise_r;
  logic [DATA_W-1:0] measure_noise_r;
  logic [1:0]        idx;
  logic              wr_en;

  assign idx   = paddr[3:2];
  assign wr_en = psel & penable & pwrite;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= SAMPLE_PERIOD_RST;
      process_noise_r <= PROCESS_NOISE_RST;
      measure_noise_r <= MEASURE_NOISE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SAMPLE_PERIOD: sample_period_r <= pwdata[TS_W-1:0];
        REG_PROCESS_NOISE: process_noise_r <= pwdata;
        REG_MEASURE_NOISE: measure_noise_r <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_SAMPLE_PERIOD: prdata = {{(DATA_W-TS_W){1'b0}}, sample_period_r};
      REG_PROCESS_NOISE: prdata = process_noise_r;
      REG_MEASURE_NOISE: prdata = measure_noise_r;
      default:           prdata = '0;
    endcase
  end

  assign cfg.sample_period    = sample_period_r;
  assign cfg.process_noise_sq = process_noise_r;
  assign cfg.measure_noise_sq = measure_noise_r;

endmodule

// ----- rtl/core/ktf_mul.sv -----
// ktf_mul: shared signed 34 x 26 multiplier with a registered product.
// Depends on ktf_pkg for the operand and product types.
`timescale 1ns / 1ps

module ktf_mul (
  input  logic            clk,
  input  logic            en,
  input  ktf_pkg::mul_a_t a,
  input  ktf_pkg::mul_b_t b,
  output ktf_pkg::prod_t  prod
);
  import ktf_pkg::*;

  prod_t prod_r;
  prod_t prod_nxt;

  // full-width signed product
  assign prod_nxt = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

// ----- rtl/core/ktf_div.sv -----
// ktf_div: radix-2 restoring divider, one quotient bit per cycle, 25 bits.
// Depends on ktf_pkg; the caller guarantees num < den * 2^25 and den != 0.
`timescale 1ns / 1ps

module ktf_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ktf_pkg::NUM_W-1:0] num,
  input  logic [ktf_pkg::DEN_W-1:0] den,
  output logic                     done,
  output logic [ktf_pkg::K_W-1:0]   quo
);
  import ktf_pkg::*;

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [K_W-1:0]   lo_r;
  logic [K_W-1:0]   quo_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             qbit;

  // one trial subtraction per cycle
  assign rem_sh = {rem_r, lo_r[K_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, den_r};
  assign qbit   = ~diff[DEN_W+1];

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= DIV_LAST;
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num[NUM_W-1:K_W]};
      lo_r  <= num[K_W-1:0];
      den_r <= den;
      quo_r <= '0;
    end else if (run_r) begin
      rem_r <= qbit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      lo_r  <= {lo_r[K_W-2:0], 1'b0};
      quo_r <= {quo_r[K_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- rtl/core/kalman_tilt_filter_2axis.sv -----
// kalman_tilt_filter_2axis: top level, sequencer and filter state.
// Depends on ktf_pkg, ktf_regs, ktf_mul and ktf_div.
`timescale 1ns / 1ps

// Two scalar Kalman filters (roll, pitch) run one after the other on one
// shared registered multiplier and one bit-per-cycle divider. An input beat
// is taken only while the sequencer is idle; each axis then runs through its
// predict, gain and correct states, the divider forming the 25-bit gain, and
// after both axes the result is loaded and the sequencer returns to idle.
// An axis whose gain denominator is zero skips the divider. The result
// register is separate, so a new beat is accepted while the previous result
// still waits; the sequencer only holds at the end if that result has not
// been taken. Configuration writes should happen while no beat is being
// processed.
module kalman_tilt_filter_2axis (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         in_rate_roll,
  input  logic signed [31:0]         in_meas_roll,
  input  logic signed [31:0]         in_rate_pitch,
  input  logic signed [31:0]         in_meas_pitch,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         out_angle_roll,
  output logic signed [31:0]         out_angle_pitch,
  output logic [31:0]                out_var_roll,
  output logic [31:0]                out_var_pitch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ktf_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [ktf_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [ktf_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                       cfg_pready
);
  import ktf_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_M1    = 4'd1;
  localparam logic [3:0] S_R1    = 4'd2;
  localparam logic [3:0] S_A1    = 4'd3;
  localparam logic [3:0] S_R2    = 4'd4;
  localparam logic [3:0] S_M3    = 4'd5;
  localparam logic [3:0] S_R3    = 4'd6;
  localparam logic [3:0] S_P1    = 4'd7;
  localparam logic [3:0] S_DEN   = 4'd8;
  localparam logic [3:0] S_DINIT = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_E     = 4'd11;
  localparam logic [3:0] S_M5    = 4'd12;
  localparam logic [3:0] S_P2    = 4'd13;
  localparam logic [3:0] S_A2    = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  ktf_cfg_t cfg;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       ax_r;

  // captured beat
  logic signed [DATA_W-1:0] rate_roll_r, meas_roll_r, rate_pitch_r, meas_pitch_r;

  // filter state, index 0 roll, 1 pitch
  logic signed [DATA_W-1:0] angle_r [2];
  logic [DATA_W-1:0]        var_r   [2];

  // working registers
  logic signed [DATA_W-1:0] a1_r;
  logic [DATA_W-1:0]        p1_r;
  logic [DEN_W-1:0]         den_r;
  logic [K_W-1:0]           k_r;
  logic signed [DATA_W:0]   e_r;
  rnd_t                     rnd_r;

  // result register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_angle_roll_r, out_angle_pitch_r;
  logic [DATA_W-1:0]        out_var_roll_r, out_var_pitch_r;

  // shared units
  mul_a_t           mul_a;
  mul_b_t           mul_b;
  logic             mul_en;
  prod_t            prod;
  logic             div_start;
  logic             div_done;
  logic [K_W-1:0]   div_quo;
  logic [NUM_W-1:0] div_num;

  logic signed [DATA_W-1:0] rate_sel, meas_sel, angle_sel;
  logic [DATA_W-1:0]        var_sel;
  logic                     in_acc;
  logic                     out_load;

  ktf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  ktf_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  ktf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign cfg_pready = 1'b1;
  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid & in_ready;
  assign out_load   = (state_r == S_DONE) & (~out_valid_r | out_ready);

  // per-axis operand select
  assign rate_sel  = ax_r ? rate_pitch_r : rate_roll_r;
  assign meas_sel  = ax_r ? meas_pitch_r : meas_roll_r;
  assign angle_sel = ax_r ? angle_r[1] : angle_r[0];
  assign var_sel   = ax_r ? var_r[1] : var_r[0];

  // gain numerator: p1 * 2^24 + den / 2
  assign div_num   = {1'b0, p1_r, 24'b0} + {25'b0, den_r[DEN_W-1:1]};
  assign div_start = (state_r == S_DINIT) & (den_r != '0);

  // multiplier operand routing
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_M1: begin
        mul_a = {{(MUL_A_W-DATA_W){rate_sel[DATA_W-1]}}, rate_sel};
        mul_b = {{(MUL_B_W-TS_W){1'b0}}, cfg.sample_period};
      end
      S_A1: begin
        mul_a = {{(MUL_A_W-TS_W){1'b0}}, cfg.sample_period};
        mul_b = {{(MUL_B_W-TS_W){1'b0}}, cfg.sample_period};
      end
      S_M3: begin
        mul_a = {{(MUL_A_W-DATA_W){1'b0}}, cfg.process_noise_sq};
        mul_b = {{(MUL_B_W-TS_W){1'b0}}, rnd_r[TS_W-1:0]};
      end
      S_E: begin
        mul_a = {{(MUL_A_W-DATA_W){1'b0}}, p1_r};
        mul_b = {1'b0, ONE_Q24 - k_r};
      end
      S_M5: begin
        mul_a = {e_r[DATA_W], e_r};
        mul_b = {1'b0, k_r};
      end
      default: mul_en = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_M1;
      S_M1:    state_nxt = S_R1;
      S_R1:    state_nxt = S_A1;
      S_A1:    state_nxt = S_R2;
      S_R2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_R3;
      S_R3:    state_nxt = S_P1;
      S_P1:    state_nxt = S_DEN;
      S_DEN:   state_nxt = S_DINIT;
      S_DINIT: state_nxt = (den_r == '0) ? S_E : S_DIV;
      S_DIV:   if (div_done) state_nxt = S_E;
      S_E:     state_nxt = S_M5;
      S_M5:    state_nxt = S_P2;
      S_P2:    state_nxt = S_A2;
      S_A2:    state_nxt = ax_r ? S_DONE : S_M1;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= 1'b0;
      out_valid_r <= 1'b0;
      angle_r[0]  <= '0;
      angle_r[1]  <= '0;
      var_r[0]    <= VAR_RST;
      var_r[1]    <= VAR_RST;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        ax_r <= 1'b0;
      end else if (state_r == S_A2) begin
        ax_r <= ~ax_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // variance after update
      if (state_r == S_P2) begin
        var_r[ax_r] <= sat_u32({rnd_r[RND_W-1], rnd_r});
      end
      // corrected angle
      if (state_r == S_A2) begin
        angle_r[ax_r] <= sat_s32({{(SUM_W-DATA_W){a1_r[DATA_W-1]}}, a1_r}
                                 + {rnd_r[RND_W-1], rnd_r});
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rnd_r <= round_q24(prod);
    if (in_acc) begin
      rate_roll_r  <= in_rate_roll;
      meas_roll_r  <= in_meas_roll;
      rate_pitch_r <= in_rate_pitch;
      meas_pitch_r <= in_meas_pitch;
    end
    // predicted angle
    if (state_r == S_A1) begin
      a1_r <= sat_s32({{(SUM_W-DATA_W){angle_sel[DATA_W-1]}}, angle_sel}
                      + {rnd_r[RND_W-1], rnd_r});
    end
    // predicted variance
    if (state_r == S_P1) begin
      p1_r <= sat_u32({{(SUM_W-DATA_W){1'b0}}, var_sel} + {rnd_r[RND_W-1], rnd_r});
    end
    if (state_r == S_DEN) begin
      den_r <= {1'b0, p1_r} + {1'b0, cfg.measure_noise_sq};
    end
    // gain, zero when the denominator is zero
    if (state_r == S_DINIT && den_r == '0) begin
      k_r <= '0;
    end else if (state_r == S_DIV && div_done) begin
      k_r <= div_quo;
    end
    // innovation
    if (state_r == S_E) begin
      e_r <= {meas_sel[DATA_W-1], meas_sel} - {a1_r[DATA_W-1], a1_r};
    end
    if (out_load) begin
      out_angle_roll_r  <= angle_r[0];
      out_angle_pitch_r <= angle_r[1];
      out_var_roll_r    <= var_r[0];
      out_var_pitch_r   <= var_r[1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_angle_roll  = out_angle_roll_r;
  assign out_angle_pitch = out_angle_pitch_r;
  assign out_var_roll    = out_var_roll_r;
  assign out_var_pitch   = out_var_pitch_r;

  // an accepted beat starts the roll axis
  a_beat_starts_roll: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_M1 && ax_r == 1'b0))
    else $error("accepted beat did not start roll axis");

  // the divider only finishes while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside of divide state");

  // gain never exceeds one
  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_E) |-> (k_r <= ONE_Q24))
    else $error("gain above one");

  // a new result only appears from the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside of done state");

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for the two-axis tilt filter. Holds its own
// fixed-point predictor of both Kalman axes, valid/ready driver and monitor, and APB setup.
// Depends on ktf_pkg and kalman_tilt_filter_2axis.
`timescale 1ns / 1ps

module tb_top;

  import ktf_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 200;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int PHASE_BEATS   = 250;
  localparam int RAND_PHASES   = 8;
  localparam int LONG_HOLD_MAX = 200;

  // register index with no register behind it
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  // filter values after reset
  localparam logic [23:0] PERIOD_AT_RESET  = 24'd167772;
  localparam logic [31:0] Q_NOISE_AT_RESET = 32'd1048576;
  localparam logic [31:0] R_NOISE_AT_RESET = 32'd589824;
  localparam logic [31:0] VAR_AT_RESET     = 32'd262144;

  localparam longint UNITY_Q24 = 64'sd16777216;
  localparam longint HALF_Q24  = 64'sd8388608;
  localparam longint S32_TOP   = 64'sd2147483647;
  localparam longint S32_BOT   = -64'sd2147483648;
  localparam longint U32_TOP   = 64'sd4294967295;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic signed [31:0] rate_roll;
    logic signed [31:0] meas_roll;
    logic signed [31:0] rate_pitch;
    logic signed [31:0] meas_pitch;
  } imu_beat_t;

  typedef struct packed {
    logic signed [31:0] angle_roll;
    logic signed [31:0] angle_pitch;
    logic [31:0]        var_roll;
    logic [31:0]        var_pitch;
  } tilt_est_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // block inputs, all known from time zero
  logic               in_valid      = 1'b0;
  logic signed [31:0] in_rate_roll  = '0;
  logic signed [31:0] in_meas_roll  = '0;
  logic signed [31:0] in_rate_pitch = '0;
  logic signed [31:0] in_meas_pitch = '0;
  logic               out_ready     = 1'b0;
  logic               cfg_psel      = 1'b0;
  logic               cfg_penable   = 1'b0;
  logic               cfg_pwrite    = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr     = '0;
  logic [DATA_W-1:0]  cfg_pwdata    = '0;

  logic               in_ready;
  logic               out_valid;
  logic signed [31:0] out_angle_roll;
  logic signed [31:0] out_angle_pitch;
  logic [31:0]        out_var_roll;
  logic [31:0]        out_var_pitch;
  logic [DATA_W-1:0]  cfg_prdata;
  logic               cfg_pready;

  kalman_tilt_filter_2axis dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rate_roll   (in_rate_roll),
    .in_meas_roll   (in_meas_roll),
    .in_rate_pitch  (in_rate_pitch),
    .in_meas_pitch  (in_meas_pitch),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_angle_roll (out_angle_roll),
    .out_angle_pitch(out_angle_pitch),
    .out_var_roll   (out_var_roll),
    .out_var_pitch  (out_var_pitch),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  // predictor copy of configuration and filter state
  logic [23:0]        period_q24 = PERIOD_AT_RESET;
  logic [31:0]        q_noise    = Q_NOISE_AT_RESET;
  logic [31:0]        r_noise    = R_NOISE_AT_RESET;
  logic signed [31:0] est_angle [2] = '{32'sd0, 32'sd0};
  logic [31:0]        est_var   [2] = '{VAR_AT_RESET, VAR_AT_RESET};

  imu_beat_t   beats_pending [$];
  tilt_est_t   tilt_expected [$];
  imu_beat_t   beat_on_bus;
  int unsigned beats_queued   = 0;
  int unsigned beats_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned send_hold      = 0;
  int unsigned recv_hold      = 0;
  int unsigned cycle_count    = 0;

  // divide by 2^24, round half up (floor of v + 2^23)
  function automatic longint rescale_q24(input longint v);
    return (v + HALF_Q24) >>> 24;
  endfunction

  function automatic logic signed [31:0] clamp_s32(input longint v);
    if (v > S32_TOP) return S32_MAX;
    if (v < S32_BOT) return S32_MIN;
    return v[31:0];
  endfunction

  // one scalar kalman step on one axis, updates the predictor state
  function automatic void kalman_axis(input int ax, input logic signed [31:0] rate,
                                      input logic signed [31:0] meas);
    longint ts, a1, ts2, p1, den, gain, err, p2;
    ts = longint'(period_q24);
    // predict
    a1  = clamp_s32(longint'(est_angle[ax]) + rescale_q24(ts * longint'(rate)));
    ts2 = rescale_q24(ts * ts);
    p1  = longint'(est_var[ax]) + rescale_q24(ts2 * longint'(q_noise));
    if (p1 > U32_TOP) p1 = U32_TOP;
    // gain in q1.24, zero when the denominator vanishes
    den = p1 + longint'(r_noise);
    if (den == 0) gain = 0;
    else gain = (p1 * UNITY_Q24 + (den >>> 1)) / den;
    if (gain > UNITY_Q24) gain = UNITY_Q24;
    // correct
    err = longint'(meas) - a1;
    est_angle[ax] = clamp_s32(a1 + rescale_q24(gain * err));
    p2 = rescale_q24(p1 * (UNITY_Q24 - gain));
    if (p2 > U32_TOP) p2 = U32_TOP;
    est_var[ax] = p2[31:0];
  endfunction

  function automatic tilt_est_t tilt_filter_step(input imu_beat_t b);
    tilt_est_t r;
    kalman_axis(0, b.rate_roll, b.meas_roll);
    kalman_axis(1, b.rate_pitch, b.meas_pitch);
    r.angle_roll  = est_angle[0];
    r.angle_pitch = est_angle[1];
    r.var_roll    = est_var[0];
    r.var_pitch   = est_var[1];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // input driver: one beat at a time from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        tilt_expected.push_back(tilt_filter_step(beat_on_bus));
        beats_accepted++;
        if (send_idle_pct != 0 && $urandom_range(15) == 0)
          send_hold = $urandom_range(LONG_HOLD_MAX, 1);
      end
      if (!in_valid || in_ready) begin
        if (send_hold != 0) begin
          send_hold--;
          in_valid <= 1'b0;
        end else if (beats_pending.size() == 0 || $urandom_range(99) < send_idle_pct) begin
          in_valid <= 1'b0;
        end else begin
          beat_on_bus = beats_pending.pop_front();
          in_valid      <= 1'b1;
          in_rate_roll  <= beat_on_bus.rate_roll;
          in_meas_roll  <= beat_on_bus.meas_roll;
          in_rate_pitch <= beat_on_bus.rate_pitch;
          in_meas_pitch <= beat_on_bus.meas_pitch;
        end
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tilt_expected.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected result: expected none actual %h %h %h %h", $time,
                   out_angle_roll, out_angle_pitch, out_var_roll, out_var_pitch);
        end else begin
          check_field("angle_roll", tilt_expected[0].angle_roll, out_angle_roll);
          check_field("angle_pitch", tilt_expected[0].angle_pitch, out_angle_pitch);
          check_field("var_roll", tilt_expected[0].var_roll, out_var_roll);
          check_field("var_pitch", tilt_expected[0].var_pitch, out_var_pitch);
          void'(tilt_expected.pop_front());
        end
        if (recv_idle_pct != 0 && $urandom_range(15) == 0)
          recv_hold = $urandom_range(LONG_HOLD_MAX, 1);
      end
      if (recv_hold != 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin
        send_idle_pct = 72;
        recv_idle_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        recv_idle_pct = 72;
      end
      IDLE_BOTH: begin
        send_idle_pct = 16;
        recv_idle_pct = 16;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // apb write: setup cycle, access cycle, register taken at the pready edge
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    @(posedge clk);
    case (idx)
      REG_SAMPLE_PERIOD: period_q24 = value[23:0];
      REG_PROCESS_NOISE: q_noise = value;
      REG_MEASURE_NOISE: r_noise = value;
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic queue_beat(input logic signed [31:0] rr, input logic signed [31:0] mr,
                            input logic signed [31:0] rp, input logic signed [31:0] mp);
    imu_beat_t b;
    b.rate_roll  = rr;
    b.meas_roll  = mr;
    b.rate_pitch = rp;
    b.meas_pitch = mp;
    beats_pending.push_back(b);
    beats_queued++;
  endtask

  // wait until every beat is taken and every estimate checked
  task automatic wait_drained();
    @(negedge clk);
    while (beats_accepted != beats_queued || tilt_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // symmetric value in [-mag, mag]
  function automatic logic signed [31:0] rand_span(input int unsigned mag);
    return int'($urandom_range(2 * mag)) - int'(mag);
  endfunction

  // mostly plausible imu samples, the rest full-range noise
  task automatic queue_random_beat();
    if ($urandom_range(9) < 7)
      queue_beat(rand_span(500 << 16), rand_span(90 << 16),
                 rand_span(500 << 16), rand_span(90 << 16));
    else
      queue_beat($urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic pick_random_config();
    logic [31:0] ts_val, q_val, r_val;
    case ($urandom_range(3))
      0: ts_val = PERIOD_AT_RESET;
      1: ts_val = $urandom_range(32'h3FFFF, 1);
      2: ts_val = $urandom_range(32'hFFFFFF, 1);
      default: ts_val = $urandom;
    endcase
    case ($urandom_range(2))
      0: q_val = Q_NOISE_AT_RESET;
      1: q_val = $urandom_range(32'hFFFFF);
      default: q_val = $urandom;
    endcase
    case ($urandom_range(3))
      0: r_val = $urandom_range(32'hFFFFF, 1);
      1: r_val = $urandom;
      2: r_val = 32'd1;
      default: r_val = ($urandom_range(3) == 0) ? 32'd0 : R_NOISE_AT_RESET;
    endcase
    write_reg(REG_SAMPLE_PERIOD, ts_val);
    write_reg(REG_PROCESS_NOISE, q_val);
    write_reg(REG_MEASURE_NOISE, r_val);
  endtask

  // stimulus sequence
  initial begin
    int ph;
    int n;
    set_idle(IDLE_NONE);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration, field extremes and bit patterns
    queue_beat(32'sd0, 32'sd0, 32'sd0, 32'sd0);
    queue_beat(S32_MAX, S32_MAX, S32_MAX, S32_MAX);
    queue_beat(S32_MIN, S32_MIN, S32_MIN, S32_MIN);
    queue_beat(S32_MAX, S32_MIN, S32_MIN, S32_MAX);
    queue_beat(S32_MIN, S32_MAX, S32_MAX, S32_MIN);
    queue_beat(32'sd0, S32_MAX, 32'sd0, S32_MIN);
    queue_beat(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555);
    queue_beat(32'sd10 << 16, 32'sd5 << 16, -(32'sd10 << 16), -(32'sd5 << 16));
    wait_drained();

    // longest period with extra value bits, largest noises: angle and variance saturate
    write_reg(REG_SAMPLE_PERIOD, 32'hA5FF_FFFF);
    write_reg(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
    write_reg(REG_MEASURE_NOISE, 32'hFFFF_FFFF);
    queue_beat(S32_MAX, S32_MAX, S32_MAX, S32_MAX);
    queue_beat(S32_MAX, 32'sd0, S32_MIN, 32'sd0);
    queue_beat(S32_MIN, S32_MIN, S32_MIN, S32_MIN);
    queue_beat(S32_MIN, S32_MAX, S32_MAX, S32_MIN);
    queue_beat(32'sd0, 32'sd0, 32'sd0, 32'sd0);
    wait_drained();

    // zero period: prediction is a no-op even with huge q
    write_reg(REG_SAMPLE_PERIOD, 32'd0);
    write_reg(REG_MEASURE_NOISE, R_NOISE_AT_RESET);
    queue_beat(S32_MAX, 32'sd100 << 16, S32_MIN, -(32'sd100 << 16));
    queue_beat(S32_MIN, 32'sd0, S32_MAX, 32'sd0);
    queue_beat(32'sd3 << 16, 32'sd1 << 16, 32'sd7 << 16, -(32'sd1 << 16));
    wait_drained();

    // unmapped write ignored; r = 0 gives unity gain, then p = 0 and a zero denominator
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    write_reg(REG_PROCESS_NOISE, 32'd0);
    write_reg(REG_MEASURE_NOISE, 32'd0);
    queue_beat(32'sd0, S32_MAX, 32'sd0, S32_MIN);
    queue_beat(S32_MAX, S32_MIN, S32_MIN, S32_MAX);
    queue_beat(32'sd0, 32'sd0, 32'sd0, 32'sd0);
    queue_beat(32'sd123 << 16, 32'sd45 << 16, -(32'sd12 << 16), -(32'sd30 << 16));
    wait_drained();

    // random phases across configurations and idle patterns
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        write_reg(REG_SAMPLE_PERIOD, 32'd1);
        write_reg(REG_PROCESS_NOISE, 32'd0);
        write_reg(REG_MEASURE_NOISE, 32'd1);
      end else if (ph == 1) begin
        write_reg(REG_SAMPLE_PERIOD, 32'h00FF_FFFF);
        write_reg(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
        write_reg(REG_MEASURE_NOISE, 32'hFFFF_FFFF);
      end else begin
        pick_random_config();
      end
      set_idle(idle_mode_t'(ph % 4));
      for (n = 0; n < PHASE_BEATS; n++) queue_random_beat();
      wait_drained();
    end

    // watch for stray results, then report
    repeat (END_CYCLES) @(negedge clk);
    if (tilt_expected.size() != 0) begin
      mismatch_count++;
      $display("%0t %0d estimates never arrived", $time, tilt_expected.size());
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
